### design/sme_pkg.sv
// shared types and constants for the six-register machine execute block
// no dependencies; used by sme_alu and six_register_machine_execute
package sme_pkg;

   localparam int NUM_REGS   = 6;
   localparam int DATA_WIDTH = 32;
   localparam int REG_IDX_W  = $clog2(NUM_REGS);

   // configuration register indexes, one 32-bit word each at 4*index
   localparam int CSR_ADDR_W = 4;

   typedef enum logic [1:0] {
      CSR_IP_BOUND    = 2'd0,
      CSR_PROG_LENGTH = 2'd1,
      CSR_STEP_LIMIT  = 2'd2,
      CSR_INITIAL_R0  = 2'd3
   } csr_index_type;

   typedef enum logic [3:0] {
      OP_ADDR = 4'd0,
      OP_ADDI = 4'd1,
      OP_MULR = 4'd2,
      OP_MULI = 4'd3,
      OP_BANR = 4'd4,
      OP_BANI = 4'd5,
      OP_BORR = 4'd6,
      OP_BORI = 4'd7,
      OP_SETR = 4'd8,
      OP_SETI = 4'd9,
      OP_GTIR = 4'd10,
      OP_GTRI = 4'd11,
      OP_GTRR = 4'd12,
      OP_EQIR = 4'd13,
      OP_EQRI = 4'd14,
      OP_EQRR = 4'd15
   } opcode_type;

   typedef logic [DATA_WIDTH-1:0] data_type;

   // operand a names a register except for seti, gtir, eqir
   function automatic logic a_is_reg(opcode_type op);
      return !(op == OP_SETI || op == OP_GTIR || op == OP_EQIR);
   endfunction

   // operand b names a register for the r forms and the ir compares
   function automatic logic b_is_reg(opcode_type op);
      return op == OP_ADDR || op == OP_MULR || op == OP_BANR || op == OP_BORR ||
             op == OP_GTIR || op == OP_GTRR || op == OP_EQIR || op == OP_EQRR;
   endfunction

endpackage

### design/sme_alu.sv
// single-operation alu of the machine: add, multiply, logic, set, compares
// depends on sme_pkg
module sme_alu (
   input  sme_pkg::opcode_type op,
   input  sme_pkg::data_type   av,
   input  sme_pkg::data_type   bv,
   output sme_pkg::data_type   res
);

   always_comb begin
      unique case (op)
         sme_pkg::OP_ADDR, sme_pkg::OP_ADDI: res = av + bv;
         sme_pkg::OP_MULR, sme_pkg::OP_MULI: res = av * bv;
         sme_pkg::OP_BANR, sme_pkg::OP_BANI: res = av & bv;
         sme_pkg::OP_BORR, sme_pkg::OP_BORI: res = av | bv;
         sme_pkg::OP_SETR, sme_pkg::OP_SETI: res = av;
         sme_pkg::OP_GTIR, sme_pkg::OP_GTRI, sme_pkg::OP_GTRR:
            res = sme_pkg::DATA_WIDTH'($signed(av) > $signed(bv));
         default: res = sme_pkg::DATA_WIDTH'(av == bv);
      endcase
   end

endmodule

### design/six_register_machine_execute.sv
// Executes one instruction of a six-register machine per word: the word is
// captured in an input register, then register read, one alu operation,
// register write and pointer update happen as it advances, ending in the
// result register. Throughput is one word per clock while the response
// channel does not stall; the input and result registers lie around the
// single alu pass (the 32x32 multiply is the long path). The pointer and
// register state update as each word completes, so a new word can follow
// every cycle unless stalled. Configuration goes through an APB-style port
// at byte addresses 0, 4, 8, 12 and should be written only while idle.
// depends on sme_pkg and sme_alu
module six_register_machine_execute (
   input  logic               clock,
   input  logic               reset,
   // request channel
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_func,
   input  logic [3:0]         req_opcode,
   input  logic signed [31:0] req_operand_a,
   input  logic signed [31:0] req_operand_b,
   input  logic [2:0]         req_dest_index,
   // response channel
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_next_pointer,
   output logic signed [31:0] rsp_reg0_value,
   output logic               rsp_halted,
   output logic               rsp_index_error,
   // configuration port
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [sme_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]                    pwdata,
   output logic [31:0]                    prdata,
   output logic                           pready
);

   localparam int DW = sme_pkg::DATA_WIDTH;
   localparam int IW = sme_pkg::REG_IDX_W;

   // configuration registers
   logic [2:0]         bound_ff;
   logic [15:0]        prog_len_ff;
   logic [30:0]        step_limit_ff;
   logic [31:0]        init_r0_ff;
   logic               csr_write;
   sme_pkg::csr_index_type csr_idx;

   // input register
   logic               in_valid_ff, in_valid_in;
   logic               x_func_ff;
   sme_pkg::opcode_type x_op_ff;
   logic [31:0]        x_a_ff, x_b_ff;
   logic [2:0]         x_dst_ff;

   // machine state
   sme_pkg::data_type  rf_ff [sme_pkg::NUM_REGS];
   sme_pkg::data_type  rf_in [sme_pkg::NUM_REGS];
   sme_pkg::data_type  ip_ff, ip_in;
   logic [30:0]        count_ff, count_in;
   logic               halt_ff, halt_in;

   // result register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [31:0]        rsp_ptr_ff, rsp_r0_ff;
   logic               rsp_halt_ff, rsp_err_ff;
   logic               err;

   logic               accept, adv;
   logic               bound_ok;
   logic [IW-1:0]      bidx, aidx, bbidx, didx;
   logic               a_reg, b_reg, a_bad, b_bad, d_bad;
   sme_pkg::data_type  rfm [sme_pkg::NUM_REGS];
   sme_pkg::data_type  av, bv, res, base;

   // ---------------- configuration port ----------------
   assign pready    = 1'b1;
   assign csr_write = psel & penable & pwrite & pready;
   assign csr_idx   = sme_pkg::csr_index_type'(paddr[3:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         bound_ff      <= '0;
         prog_len_ff   <= 16'd1;
         step_limit_ff <= 31'h7fff_ffff;
         init_r0_ff    <= '0;
      end else if (csr_write) begin
         unique case (csr_idx)
            sme_pkg::CSR_IP_BOUND:    bound_ff      <= pwdata[2:0];
            sme_pkg::CSR_PROG_LENGTH: prog_len_ff   <= pwdata[15:0];
            sme_pkg::CSR_STEP_LIMIT:  step_limit_ff <= pwdata[30:0];
            sme_pkg::CSR_INITIAL_R0:  init_r0_ff    <= pwdata;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         sme_pkg::CSR_IP_BOUND:    prdata = {29'd0, bound_ff};
         sme_pkg::CSR_PROG_LENGTH: prdata = {16'd0, prog_len_ff};
         sme_pkg::CSR_STEP_LIMIT:  prdata = {1'b0, step_limit_ff};
         sme_pkg::CSR_INITIAL_R0:  prdata = init_r0_ff;
      endcase
   end

   // ---------------- handshake ----------------
   assign adv         = in_valid_ff & (~rsp_valid_ff | rsp_ready);
   assign req_ready   = ~in_valid_ff | adv;
   assign accept      = req_valid & req_ready;
   assign in_valid_in = accept | (in_valid_ff & ~adv);
   assign rsp_valid_in = adv | (rsp_valid_ff & ~rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         x_func_ff <= req_func;
         x_op_ff   <= sme_pkg::opcode_type'(req_opcode);
         x_a_ff    <= req_operand_a;
         x_b_ff    <= req_operand_b;
         x_dst_ff  <= req_dest_index;
      end
   end

   // ---------------- execute ----------------
   assign bound_ok = int'(bound_ff) < sme_pkg::NUM_REGS;
   assign bidx     = IW'(bound_ff);
   assign aidx     = x_a_ff[IW-1:0];
   assign bbidx    = x_b_ff[IW-1:0];
   assign didx     = IW'(x_dst_ff);
   assign a_reg    = sme_pkg::a_is_reg(x_op_ff);
   assign b_reg    = sme_pkg::b_is_reg(x_op_ff);
   assign a_bad    = x_a_ff >= 32'(sme_pkg::NUM_REGS);
   assign b_bad    = x_b_ff >= 32'(sme_pkg::NUM_REGS);
   assign d_bad    = int'(x_dst_ff) >= sme_pkg::NUM_REGS;
   assign err      = d_bad | (a_reg & a_bad) | (b_reg & b_bad);

   // register file as seen by the instruction: pointer mirrored first
   always_comb begin
      for (int i = 0; i < sme_pkg::NUM_REGS; i++) begin
         rfm[i] = (bound_ok && IW'(i) == bidx) ? ip_ff : rf_ff[i];
      end
   end

   assign av = a_reg ? rfm[aidx] : DW'($signed(x_a_ff));
   assign bv = b_reg ? rfm[bbidx] : DW'($signed(x_b_ff));

   sme_alu u_alu (
      .op  (x_op_ff),
      .av  (av),
      .bv  (bv),
      .res (res)
   );

   // pointer base: bound register after the write, or the old pointer
   always_comb begin
      if (!bound_ok) begin
         base = ip_ff;
      end else if (!err && didx == bidx) begin
         base = res;
      end else begin
         base = ip_ff;
      end
   end

   always_comb begin
      for (int i = 0; i < sme_pkg::NUM_REGS; i++) begin
         rf_in[i] = rf_ff[i];
      end
      ip_in    = ip_ff;
      count_in = count_ff;
      halt_in  = halt_ff;
      priority if (x_func_ff) begin
         // restart: clear, load r0, take pointer from the bound register
         for (int i = 0; i < sme_pkg::NUM_REGS; i++) begin
            rf_in[i] = '0;
         end
         rf_in[0] = DW'($signed(init_r0_ff));
         if (bound_ok && bidx == '0) begin
            ip_in = DW'($signed(init_r0_ff));
         end else begin
            ip_in = '0;
         end
         count_in = '0;
         halt_in  = ip_in[DW-1] || (ip_in >= DW'(prog_len_ff)) ||
                    (step_limit_ff <= 31'd1);
      end else if (!halt_ff) begin
         for (int i = 0; i < sme_pkg::NUM_REGS; i++) begin
            rf_in[i] = rfm[i];
         end
         if (!err) begin
            rf_in[didx] = res;
         end
         ip_in    = base + DW'(1);
         count_in = count_ff + 31'd1;
         halt_in  = ip_in[DW-1] || (ip_in >= DW'(prog_len_ff)) ||
                    (({1'b0, count_in} + 32'd1) >= {1'b0, step_limit_ff});
      end else begin
         // halted: state holds
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < sme_pkg::NUM_REGS; i++) begin
            rf_ff[i] <= '0;
         end
         ip_ff    <= '0;
         count_ff <= '0;
         halt_ff  <= 1'b0;
      end else if (adv) begin
         for (int i = 0; i < sme_pkg::NUM_REGS; i++) begin
            rf_ff[i] <= rf_in[i];
         end
         ip_ff    <= ip_in;
         count_ff <= count_in;
         halt_ff  <= halt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_ptr_ff  <= ip_in[31:0];
         rsp_r0_ff   <= rf_in[0][31:0];
         rsp_halt_ff <= halt_in;
         rsp_err_ff  <= ~x_func_ff & ~halt_ff & err;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_next_pointer = rsp_ptr_ff;
   assign rsp_reg0_value   = rsp_r0_ff;
   assign rsp_halted       = rsp_halt_ff;
   assign rsp_index_error  = rsp_err_ff;

   // ---------------- assertions ----------------
   a_reset_state: assert property (@(posedge clock)
      reset |=> (!halt_ff && ip_ff == '0 && count_ff == '0))
      else $error("machine state not cleared by reset");

   a_restart_count: assert property (@(posedge clock) disable iff (reset)
      (adv && x_func_ff) |=> (count_ff == '0))
      else $error("restart did not clear executed count");

   a_halted_holds: assert property (@(posedge clock) disable iff (reset)
      (adv && !x_func_ff && halt_ff) |=> ($stable(ip_ff) && $stable(count_ff) && halt_ff))
      else $error("halted machine changed state");

   a_step_count: assert property (@(posedge clock) disable iff (reset)
      (adv && !x_func_ff && !halt_ff) |=> (count_ff == $past(count_ff) + 31'd1))
      else $error("executed count did not advance");

   a_empty_ready: assert property (@(posedge clock) disable iff (reset)
      !in_valid_ff |-> req_ready)
      else $error("empty input register refused a word");

endmodule
